[hw/rtl/tslf_pkg.sv]
// Shared types and constants for the three-sensor line follower.
package tslf_pkg;

  localparam int unsigned ReadingW = 12;
  localparam int unsigned PulseW   = 16;
  localparam int unsigned SpeedW   = 7;
  localparam int unsigned DirW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_THR_LEFT   = 3'd0,
    CFG_THR_MIDDLE = 3'd1,
    CFG_THR_RIGHT  = 3'd2,
    CFG_WIN_LOW    = 3'd3,
    CFG_WIN_HIGH   = 3'd4
  } cfg_idx_e;

  localparam logic [ReadingW-1:0] ThrLeftRst   = 12'd800;
  localparam logic [ReadingW-1:0] ThrMiddleRst = 12'd750;
  localparam logic [ReadingW-1:0] ThrRightRst  = 12'd800;
  localparam logic [PulseW-1:0]   WinLowRst    = 16'd1450;
  localparam logic [PulseW-1:0]   WinHighRst   = 16'd1550;

  // Side on which the line was last seen
  typedef enum logic [1:0] {
    SIDE_CENTER = 2'd0,
    SIDE_LEFT   = 2'd1,
    SIDE_RIGHT  = 2'd2
  } side_e;

  // Motor direction codes (unmirrored view)
  typedef enum logic [DirW-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  localparam logic [2:0] SlowPhaseLast = 3'd4;
  localparam logic [1:0] SearchSteps   = 2'd2;

  typedef struct packed {
    side_e      last_side;
    logic [2:0] slow_phase;
    logic [1:0] search_count;
  } steer_state_t;

  typedef struct packed {
    logic [SpeedW-1:0] right_speed;
    dir_e              right_direction;
    logic [SpeedW-1:0] left_speed;
    dir_e              left_direction;
  } motor_cmd_t;

  typedef struct packed {
    logic [ReadingW-1:0] thr_right;
    logic [ReadingW-1:0] thr_middle;
    logic [ReadingW-1:0] thr_left;
  } thresholds_t;

endpackage

[hw/rtl/three_sensor_line_follower_core.sv]
// Top level of the three-sensor line follower core.
//
// Input stream (s_axis_*): one word per sample set, three 12-bit reflectance
// readings and a 16-bit remote-control pulse width. A word whose pulse width
// lies strictly inside the configured window makes one steering update and
// yields one output word; any other word is dropped without touching state.
// Output stream (m_axis_*): left and right motor direction and speed, the
// right motor mirrored (2 forward, 1 reverse).
// Configuration: cfg_valid_i/cfg_ready_o with a register index and data;
// write only while the core is idle. Unknown indexes are ignored.
//
// An accepted word lands in the input register, and its result is
// registered in the output register; a word for a stalled output waits in
// the input register.
// Throughput: one word per cycle while the output is not stalled; the update
// is a few compares and a table pick between the input and output registers.
// A stalled receiver holds the output word; the input register still takes
// one more word and drains dropped words freely, then tready falls.
// Reset clears both valid flags, the steering state and restores the
// default thresholds and window.
module three_sensor_line_follower_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream, tdata fields from bit 0 up: reading_left[11:0],
  // reading_middle[23:12], reading_right[35:24], rc_pulse_width[51:36], zero pad
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tslf_pkg::InDataW-1:0]    s_axis_tdata,
  // Output stream, tdata fields from bit 0 up: left_direction[1:0],
  // left_speed[8:2], right_direction[10:9], right_speed[17:11], zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tslf_pkg::OutDataW-1:0]   m_axis_tdata,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tslf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tslf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tslf_pkg::*;

  // Configuration registers
  thresholds_t       thr_q;
  logic [PulseW-1:0] win_low_q, win_high_q;

  // Input register
  logic                s1_valid_q;
  logic [ReadingW-1:0] rl_q, rm_q, rr_q;
  logic [PulseW-1:0]   pw_q;

  // Steering state and output register
  steer_state_t state_q, state_d;
  motor_cmd_t   cmd_d, cmd_q;
  logic         out_valid_q;

  logic s_accept, window_hit, out_free, s1_move, update;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.thr_left   <= ThrLeftRst;
      thr_q.thr_middle <= ThrMiddleRst;
      thr_q.thr_right  <= ThrRightRst;
      win_low_q        <= WinLowRst;
      win_high_q       <= WinHighRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_THR_LEFT:   thr_q.thr_left   <= cfg_data_i[ReadingW-1:0];
        CFG_THR_MIDDLE: thr_q.thr_middle <= cfg_data_i[ReadingW-1:0];
        CFG_THR_RIGHT:  thr_q.thr_right  <= cfg_data_i[ReadingW-1:0];
        CFG_WIN_LOW:    win_low_q        <= cfg_data_i;
        CFG_WIN_HIGH:   win_high_q       <= cfg_data_i;
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // A word outside the window leaves without needing the output slot
  assign window_hit    = (pw_q > win_low_q) && (pw_q < win_high_q);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && (!window_hit || out_free);
  assign update        = s1_move && window_hit;
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Payload: load on accept, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      rl_q <= s_axis_tdata[11:0];
      rm_q <= s_axis_tdata[23:12];
      rr_q <= s_axis_tdata[35:24];
      pw_q <= s_axis_tdata[51:36];
    end
  end

  tslf_steer u_steer (
    .reading_left_i   (rl_q),
    .reading_middle_i (rm_q),
    .reading_right_i  (rr_q),
    .thr_i            (thr_q),
    .state_i          (state_q),
    .state_o          (state_d),
    .cmd_o            (cmd_d)
  );

  // Advance the steering state only on a qualifying update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.last_side    <= SIDE_CENTER;
      state_q.slow_phase   <= '0;
      state_q.search_count <= '0;
    end else if (update) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (update) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (update) begin
      cmd_q <= cmd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, cmd_q.right_speed, cmd_q.right_direction,
                          cmd_q.left_speed, cmd_q.left_direction};

endmodule

[hw/rtl/tslf_steer.sv]
// Steering decision: sensor compares, speed table, search and state update.
module tslf_steer (
  input  logic [tslf_pkg::ReadingW-1:0] reading_left_i,
  input  logic [tslf_pkg::ReadingW-1:0] reading_middle_i,
  input  logic [tslf_pkg::ReadingW-1:0] reading_right_i,
  input  tslf_pkg::thresholds_t         thr_i,
  input  tslf_pkg::steer_state_t        state_i,
  output tslf_pkg::steer_state_t        state_o,
  output tslf_pkg::motor_cmd_t          cmd_o
);
  import tslf_pkg::*;

  localparam logic signed [7:0] MaxSpeed = 8'sd100;

  typedef struct packed {
    dir_e              dir;
    logic [SpeedW-1:0] mag;
  } motor_t;

  function automatic motor_t motor_enc(input logic signed [7:0] v, input logic mirrored);
    logic signed [7:0] c;
    motor_t m;
    c = v;
    if (c > MaxSpeed) c = MaxSpeed;
    if (c < -MaxSpeed) c = -MaxSpeed;
    if (c == 8'sd0) begin
      m.dir = DIR_STOP;
      m.mag = '0;
    end else if (c > 8'sd0) begin
      m.dir = mirrored ? DIR_REV : DIR_FWD;
      m.mag = c[SpeedW-1:0];
    end else begin
      m.dir = mirrored ? DIR_FWD : DIR_REV;
      m.mag = 7'(-c);
    end
    return m;
  endfunction

  logic              sl, sm, sr, slow;
  logic signed [7:0] lv, rv;
  motor_t            lm, rm;

  assign sl = reading_left_i   > thr_i.thr_left;
  assign sm = reading_middle_i > thr_i.thr_middle;
  assign sr = reading_right_i  > thr_i.thr_right;

  // Slow step when the phase counter steps onto its last value
  assign slow = (state_i.slow_phase == SlowPhaseLast - 3'd1);

  always_comb begin
    state_o = state_i;
    state_o.slow_phase = (state_i.slow_phase >= SlowPhaseLast) ? 3'd0
                                                               : state_i.slow_phase + 3'd1;
    state_o.search_count = '0;
    lv = slow ? 8'sd40 : 8'sd55;
    rv = lv;
    case ({sl, sm, sr})
      3'b010: begin
        state_o.last_side = SIDE_CENTER;
      end
      3'b110: begin
        state_o.last_side = SIDE_LEFT;
        lv = slow ? 8'sd35 : 8'sd45;
        rv = slow ? 8'sd55 : 8'sd70;
      end
      3'b100: begin
        state_o.last_side = SIDE_LEFT;
        lv = slow ? 8'sd30 : 8'sd40;
        rv = slow ? 8'sd60 : 8'sd80;
      end
      3'b011: begin
        state_o.last_side = SIDE_RIGHT;
        lv = slow ? 8'sd55 : 8'sd70;
        rv = slow ? 8'sd35 : 8'sd45;
      end
      3'b001: begin
        state_o.last_side = SIDE_RIGHT;
        lv = slow ? 8'sd60 : 8'sd80;
        rv = slow ? 8'sd30 : 8'sd40;
      end
      3'b111: begin
        // all on: cruise, keep last side
      end
      3'b101: begin
        // split: follow the remembered side
        case (state_i.last_side)
          SIDE_LEFT: begin
            lv = slow ? 8'sd35 : 8'sd45;
            rv = slow ? 8'sd55 : 8'sd70;
          end
          SIDE_RIGHT: begin
            lv = slow ? 8'sd55 : 8'sd70;
            rv = slow ? 8'sd35 : 8'sd45;
          end
          default: begin
          end
        endcase
      end
      default: begin
        // line lost: spin toward last side (back up if centred), then stop and rearm
        if (state_i.search_count < SearchSteps) begin
          state_o.search_count = state_i.search_count + 2'd1;
          case (state_i.last_side)
            SIDE_LEFT: begin
              lv = slow ? 8'sd85 : 8'sd90;
              rv = -lv;
            end
            SIDE_RIGHT: begin
              rv = slow ? 8'sd85 : 8'sd90;
              lv = -rv;
            end
            default: begin
              lv = -8'sd70;
              rv = -8'sd70;
            end
          endcase
        end else begin
          lv = 8'sd0;
          rv = 8'sd0;
        end
      end
    endcase
  end

  assign lm = motor_enc(lv, 1'b0);
  assign rm = motor_enc(rv, 1'b1);

  assign cmd_o.left_direction  = lm.dir;
  assign cmd_o.left_speed      = lm.mag;
  assign cmd_o.right_direction = rm.dir;
  assign cmd_o.right_speed     = rm.mag;

endmodule

[hw/rtl/tslf_checker.sv]
// Port-level checker for the line follower core and its bind.
module tslf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tslf_pkg::OutDataW-1:0] m_axis_tdata
);
  import tslf_pkg::*;

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Input backpressure only while the output is stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // Stop direction exactly when a speed is zero
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[1:0] == DIR_STOP) == (m_axis_tdata[8:2] == 7'd0)) &&
                      ((m_axis_tdata[10:9] == DIR_STOP) == (m_axis_tdata[17:11] == 7'd0)))
    else $error("direction and speed disagree on stop");

  // Speeds stay within the clamp
  a_speed_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:2] <= 7'd100) && (m_axis_tdata[17:11] <= 7'd100))
    else $error("speed above clamp");

endmodule

bind three_sensor_line_follower_core tslf_checker u_tslf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/tb_three_sensor_line_follower_core.sv]
// Self-checking testbench for the three-sensor line follower core.
module tb_three_sensor_line_follower_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tslf_pkg::*;

  // One input word, first field in the lowest bits
  typedef struct packed {
    logic [PulseW-1:0]   pulse;
    logic [ReadingW-1:0] right;
    logic [ReadingW-1:0] middle;
    logic [ReadingW-1:0] left;
  } sensor_word_t;

  localparam logic [CfgIdxW-1:0] CfgIdxFirstUnused = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgIdxMax         = {CfgIdxW{1'b1}};
  localparam int unsigned        MotorW            = $bits(motor_cmd_t);

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  three_sensor_line_follower_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Steering model: configuration copy and state
  logic [ReadingW-1:0] thr_left, thr_middle, thr_right;
  logic [PulseW-1:0]   win_low, win_high;
  side_e               follow_side;
  logic [2:0]          update_phase;
  logic [1:0]          search_steps;

  motor_cmd_t  expected_cmds_q[$];
  int unsigned mismatches;

  // Traffic shaping, set by the tests
  bit tx_gaps_on;
  bit rx_stalls_on;
  int unsigned rx_hold_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  function automatic void speed_to_motor(input int v, input bit mirrored,
                                         output dir_e dir, output logic [SpeedW-1:0] mag);
    if (v > 100) v = 100;
    if (v < -100) v = -100;
    if (v == 0) begin
      dir = DIR_STOP;
      mag = '0;
    end else if (v > 0) begin
      dir = mirrored ? DIR_REV : DIR_FWD;
      mag = SpeedW'(v);
    end else begin
      dir = mirrored ? DIR_FWD : DIR_REV;
      mag = SpeedW'(-v);
    end
  endfunction

  // Advance the steering model by one word; returns 1 when a command results
  function automatic bit predict_motor_cmd(input sensor_word_t w, output motor_cmd_t cmd);
    logic seen_l, seen_m, seen_r, slow;
    int   lv, rv;
    cmd = '0;
    if (!(w.pulse > win_low && w.pulse < win_high)) return 1'b0;
    seen_l = w.left > thr_left;
    seen_m = w.middle > thr_middle;
    seen_r = w.right > thr_right;
    update_phase = (update_phase >= SlowPhaseLast) ? 3'd0 : update_phase + 3'd1;
    slow = (update_phase == SlowPhaseLast);

    if (seen_m && !seen_l && !seen_r) begin
      follow_side = SIDE_CENTER; search_steps = '0;
      lv = slow ? 40 : 55; rv = lv;
    end else if (seen_l && seen_m && !seen_r) begin
      follow_side = SIDE_LEFT; search_steps = '0;
      lv = slow ? 35 : 45; rv = slow ? 55 : 70;
    end else if (seen_l && !seen_m && !seen_r) begin
      follow_side = SIDE_LEFT; search_steps = '0;
      lv = slow ? 30 : 40; rv = slow ? 60 : 80;
    end else if (!seen_l && seen_m && seen_r) begin
      follow_side = SIDE_RIGHT; search_steps = '0;
      lv = slow ? 55 : 70; rv = slow ? 35 : 45;
    end else if (!seen_l && !seen_m && seen_r) begin
      follow_side = SIDE_RIGHT; search_steps = '0;
      lv = slow ? 60 : 80; rv = slow ? 30 : 40;
    end else if (seen_l && seen_m && seen_r) begin
      search_steps = '0;
      lv = slow ? 40 : 55; rv = lv;
    end else if (seen_l && !seen_m && seen_r) begin
      // split line: steer as if the line sat on the remembered side
      search_steps = '0;
      case (follow_side)
        SIDE_LEFT:  begin lv = slow ? 35 : 45; rv = slow ? 55 : 70; end
        SIDE_RIGHT: begin lv = slow ? 55 : 70; rv = slow ? 35 : 45; end
        default:    begin lv = slow ? 40 : 55; rv = lv; end
      endcase
    end else if (search_steps < SearchSteps) begin
      // line lost: spin toward the remembered side, back up if none
      search_steps = search_steps + 2'd1;
      case (follow_side)
        SIDE_LEFT:  begin lv = slow ? 85 : 90; rv = -lv; end
        SIDE_RIGHT: begin rv = slow ? 85 : 90; lv = -rv; end
        default:    begin lv = -70; rv = -70; end
      endcase
    end else begin
      search_steps = '0;
      lv = 0; rv = 0;
    end

    speed_to_motor(lv, 1'b0, cmd.left_direction, cmd.left_speed);
    speed_to_motor(rv, 1'b1, cmd.right_direction, cmd.right_speed);
    return 1'b1;
  endfunction

  function automatic sensor_word_t word_of(input int l, input int m, input int r,
                                           input int p);
    sensor_word_t w;
    w.left   = ReadingW'(l);
    w.middle = ReadingW'(m);
    w.right  = ReadingW'(r);
    w.pulse  = PulseW'(p);
    return w;
  endfunction

  // Offer one word, hold it until taken, then record what it should cause
  task automatic send_word(input sensor_word_t w);
    int unsigned gap;
    motor_cmd_t  cmd;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(w);
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_motor_cmd(w, cmd)) expected_cmds_q.push_back(cmd);
  endtask

  // Drop valid, drain all results and let dropped words clear the pipe
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_cmds_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_THR_LEFT:   thr_left   = value[ReadingW-1:0];
      CFG_THR_MIDDLE: thr_middle = value[ReadingW-1:0];
      CFG_THR_RIGHT:  thr_right  = value[ReadingW-1:0];
      CFG_WIN_LOW:    win_low    = value;
      CFG_WIN_HIGH:   win_high   = value;
      default: ;
    endcase
  endtask

  // Write all five registers back to back; the core must be idle
  task automatic apply_config(input logic [CfgDataW-1:0] tl, input logic [CfgDataW-1:0] tm,
                              input logic [CfgDataW-1:0] tr, input logic [CfgDataW-1:0] lo,
                              input logic [CfgDataW-1:0] hi);
    cfg_write(CFG_THR_LEFT, tl);
    cfg_write(CFG_THR_MIDDLE, tm);
    cfg_write(CFG_THR_RIGHT, tr);
    cfg_write(CFG_WIN_LOW, lo);
    cfg_write(CFG_WIN_HIGH, hi);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ReadingW-1:0] reading_for(input bit seen,
                                                      input logic [ReadingW-1:0] thr);
    if (seen) begin
      if (thr == '1) return '1;
      if ($urandom_range(3) == 0) return thr + 1'b1;
      return ReadingW'($urandom_range(4095, thr + 1));
    end
    if ($urandom_range(3) == 0) return thr;
    return ReadingW'($urandom_range(thr, 0));
  endfunction

  // Mostly well-formed words for the current setting, some pure noise
  function automatic sensor_word_t random_word();
    sensor_word_t w;
    int unsigned  pick;
    logic [2:0]   lit;
    w.left   = ReadingW'($urandom);
    w.middle = ReadingW'($urandom);
    w.right  = ReadingW'($urandom);
    w.pulse  = PulseW'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) return w;
    // favor a lost line so search runs reach the stop step
    lit = ($urandom_range(99) < 25) ? 3'b000 : 3'($urandom_range(7));
    w.left   = reading_for(lit[2], thr_left);
    w.middle = reading_for(lit[1], thr_middle);
    w.right  = reading_for(lit[0], thr_right);
    if (pick < 92 && win_high > win_low + 1)
      w.pulse = PulseW'($urandom_range(win_high - 1, win_low + 1));
    return w;
  endfunction

  function automatic void flag_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
  endfunction

  // Compare every taken output word with the oldest expected command
  always @(posedge clk_i) begin
    motor_cmd_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = motor_cmd_t'(m_axis_tdata[MotorW-1:0]);
      if (expected_cmds_q.size() == 0) begin
        flag_mismatch("word with none expected", 0, 32'(m_axis_tdata));
      end else begin
        want = expected_cmds_q.pop_front();
        if (got.left_direction !== want.left_direction)
          flag_mismatch("left_direction", 32'(want.left_direction),
                        32'(got.left_direction));
        if (got.left_speed !== want.left_speed)
          flag_mismatch("left_speed", 32'(want.left_speed), 32'(got.left_speed));
        if (got.right_direction !== want.right_direction)
          flag_mismatch("right_direction", 32'(want.right_direction),
                        32'(got.right_direction));
        if (got.right_speed !== want.right_speed)
          flag_mismatch("right_speed", 32'(want.right_speed), 32'(got.right_speed));
        if (m_axis_tdata[OutDataW-1:MotorW] !== '0)
          flag_mismatch("tdata pad", 0, 32'(m_axis_tdata[OutDataW-1:MotorW]));
      end
    end
  end

  // Receiver: long hold first, then random stalls or always ready
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else if (!rx_stalls_on) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Default setting: every sensor pattern, threshold edges, search runs,
  // split line under each remembered side, window edges
  task automatic test_table_defaults();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    send_word(word_of(0, 0, 0, 1500));          // back up, centred
    send_word(word_of(0, 750, 800, 1500));      // still lost at threshold
    send_word(word_of(800, 0, 0, 1500));        // third loss: stop
    send_word(word_of(0, 751, 0, 1500));        // middle only
    send_word(word_of(4095, 0, 4095, 1500));    // split, centred
    send_word(word_of(801, 4095, 800, 1500));   // left+middle
    send_word(word_of(4095, 0, 4095, 1500));    // split follows left
    send_word(word_of(4095, 750, 0, 1500));     // left only
    send_word(word_of(0, 0, 0, 1500));          // spin left
    send_word(word_of(0, 0, 0, 1500));
    send_word(word_of(0, 0, 0, 1500));          // stop
    send_word(word_of(0, 0, 0, 1500));          // fresh search
    send_word(word_of(0, 751, 801, 1500));      // middle+right
    send_word(word_of(4095, 0, 4095, 1500));    // split follows right
    send_word(word_of(0, 0, 4095, 1500));       // right only
    send_word(word_of(0, 0, 0, 1500));          // spin right
    send_word(word_of(0, 0, 0, 1500));
    send_word(word_of(4095, 4095, 4095, 1500)); // all three
    send_word(word_of(4095, 4095, 4095, 1450)); // window edges
    send_word(word_of(4095, 4095, 4095, 1451));
    send_word(word_of(0, 4095, 0, 1549));
    send_word(word_of(0, 4095, 0, 1550));
    send_word(word_of(0, 4095, 0, 0));
    send_word(word_of(0, 4095, 0, 65535));
    settle();
  endtask

  // Register extremes, empty and inverted windows, writes past the last index
  task automatic test_config_extremes();
    logic [CfgIdxW-1:0] idx;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;

    apply_config(16'h0FFF, 16'h0FFF, 16'h0FFF, 16'd0, 16'hFFFF);
    send_word(word_of(4095, 4095, 4095, 0));
    send_word(word_of(4095, 4095, 4095, 1));
    send_word(word_of(4095, 4095, 4095, 65534));
    send_word(word_of(4095, 4095, 4095, 65535));
    repeat (8) send_word(random_word());
    settle();

    // upper data bits must not reach a threshold
    apply_config(16'hF000, 16'hA000, 16'h5000, 16'd1000, 16'd1001);
    send_word(word_of(1, 0, 0, 1000));
    send_word(word_of(1, 0, 0, 1001));
    repeat (10) send_word(random_word());
    settle();

    apply_config(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    repeat (10) send_word(random_word());
    settle();

    // ignored indexes must leave the setting untouched
    apply_config(16'd0, 16'd0, 16'd0, 16'd10, 16'd12);
    @(posedge clk_i);
    for (idx = CfgIdxFirstUnused; ; idx++) begin
      cfg_write(idx, 16'($urandom));
      if (idx == CfgIdxMax) break;
    end
    cfg_valid_i <= 1'b0;
    send_word(word_of(1, 0, 0, 11));
    send_word(word_of(0, 0, 1, 11));
    send_word(word_of(0, 1, 0, 11));
    send_word(word_of(0, 0, 0, 11));
    repeat (8) send_word(random_word());
    settle();
  endtask

  // Hold the receiver off long enough that the core stalls its input
  task automatic test_backpressure();
    apply_config(16'd2000, 16'd2000, 16'd2000, 16'd0, 16'hFFFF);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_left = 300;
    repeat (60) send_word(random_word());
    settle();
  endtask

  // Random settings per phase, random traffic shaping
  task automatic test_random_traffic();
    logic [CfgDataW-1:0] lo;
    for (int phase = 0; phase < 14; phase++) begin
      lo = CfgDataW'($urandom_range(65000));
      case (phase)
        0: apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 16'hFFFF);
        1: apply_config(16'd0, 16'd0, 16'd0, lo, lo + 16'($urandom_range(535, 2)));
        2: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, lo, 16'hFFFF);
        default:
          apply_config(16'($urandom), 16'($urandom), 16'($urandom), lo,
                       lo + 16'($urandom_range(65535 - lo, 2)));
      endcase
      tx_gaps_on   = (phase % 3) != 0;
      rx_stalls_on = (phase % 3) != 1;
      repeat (100) send_word(random_word());
      settle();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    tx_gaps_on    = 1'b0;
    rx_stalls_on  = 1'b0;
    rx_hold_left  = 0;
    mismatches    = 0;
    thr_left      = ThrLeftRst;
    thr_middle    = ThrMiddleRst;
    thr_right     = ThrRightRst;
    win_low       = WinLowRst;
    win_high      = WinHighRst;
    follow_side   = SIDE_CENTER;
    update_phase  = '0;
    search_steps  = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_defaults();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();

    while (expected_cmds_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_cmds_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
